@@ rtl/qssrs_pkg.sv @@
package qssrs_pkg;

  localparam int POINT_W    = 40;
  localparam int STEPS_W    = 6;
  localparam int COEF_W     = 32;
  localparam int TOL_W      = 20;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 5;
  localparam int CHUNK_W    = 32;
  localparam int IN_DATA_W  = 80;
  localparam int OUT_DATA_W = 48;
  localparam logic [STEPS_W-1:0] MAX_MOVES = 6'd63;

  typedef enum logic [2:0] {
    REG_CUBIC  = 3'd0,
    REG_SQUARE = 3'd1,
    REG_LINEAR = 3'd2,
    REG_CONST  = 3'd3,
    REG_TOL    = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] cubic;
    logic signed [COEF_W-1:0] square;
    logic signed [COEF_W-1:0] linear;
    logic signed [COEF_W-1:0] const_term;
  } coef_set_t;

  typedef struct packed {
    logic done;
    logic zero;
    logic neg;
  } horner_stat_t;

endpackage

@@ rtl/qssrs_horner.sv @@
module qssrs_horner
  import qssrs_pkg::*;
#(
  parameter int FRACTION_BITS = 24,
  parameter int SAT_W         = 40
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic signed [POINT_W-1:0] x,
  input  coef_set_t                 coefs,
  output horner_stat_t              stat
);

  localparam int MAXFS  = (FRACTION_BITS > SAT_W) ? FRACTION_BITS : SAT_W;
  localparam int NCH    = (4 * MAXFS + 35 + CHUNK_W - 1) / CHUNK_W;
  localparam int ACC_W  = NCH * CHUNK_W;
  localparam int CNT_W  = $clog2(NCH);
  localparam int PROD_W = CHUNK_W + 1 + POINT_W;
  localparam int CY_W   = PROD_W + 1 - CHUNK_W;

  typedef enum logic [3:0] {
    H_IDLE = 4'b0001,
    H_MUL  = 4'b0010,
    H_ADD  = 4'b0100,
    H_CHK  = 4'b1000
  } h_state_t;

  h_state_t              state_r, state_nxt;
  reg_idx_t              k_r, k_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [ACC_W-1:0]      acc_r, acc_nxt;
  logic [CY_W-1:0]       cy_r, cy_nxt;

  logic                  top_chunk;
  logic signed [CHUNK_W:0]   chunk_s;
  logic signed [PROD_W-1:0]  prod;
  logic [PROD_W:0]       tsum;
  logic [ACC_W-1:0]      term;

  function automatic logic [ACC_W-1:0] widen(input logic [COEF_W-1:0] c);
    return {{(ACC_W-COEF_W){c[COEF_W-1]}}, c};
  endfunction

  assign top_chunk = (cnt_r == CNT_W'(NCH - 1));
  assign chunk_s   = {top_chunk & acc_r[CHUNK_W-1], acc_r[CHUNK_W-1:0]};
  assign prod      = chunk_s * x;
  assign tsum      = {prod[PROD_W-1], prod}
                   + {{(PROD_W + 1 - CY_W){cy_r[CY_W-1]}}, cy_r};

  always_comb begin
    case (k_r)
      REG_SQUARE: term = widen(coefs.square) << (2 * FRACTION_BITS);
      REG_LINEAR: term = widen(coefs.linear) << (3 * FRACTION_BITS);
      REG_CONST:  term = widen(coefs.const_term) << (4 * FRACTION_BITS);
      default:    term = '0;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    cnt_nxt   = cnt_r;
    acc_nxt   = acc_r;
    cy_nxt    = cy_r;
    case (state_r)
      H_IDLE: begin
        if (start) begin
          acc_nxt   = {{(ACC_W-POINT_W){x[POINT_W-1]}}, x}
                    + (widen(coefs.cubic) << FRACTION_BITS);
          k_nxt     = REG_SQUARE;
          cnt_nxt   = '0;
          cy_nxt    = '0;
          state_nxt = H_MUL;
        end
      end
      H_MUL: begin
        acc_nxt = {tsum[CHUNK_W-1:0], acc_r[ACC_W-1:CHUNK_W]};
        cy_nxt  = tsum[PROD_W:CHUNK_W];
        if (top_chunk) begin
          cnt_nxt   = '0;
          state_nxt = H_ADD;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      H_ADD: begin
        acc_nxt = acc_r + term;
        cy_nxt  = '0;
        case (k_r)
          REG_SQUARE: begin
            k_nxt     = REG_LINEAR;
            state_nxt = H_MUL;
          end
          REG_LINEAR: begin
            k_nxt     = REG_CONST;
            state_nxt = H_MUL;
          end
          default: state_nxt = H_CHK;
        endcase
      end
      H_CHK:   state_nxt = H_IDLE;
      default: state_nxt = H_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= H_IDLE;
      k_r     <= REG_SQUARE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    cy_r  <= cy_nxt;
  end

  assign stat.done = (state_r == H_CHK);
  assign stat.zero = (acc_r == '0);
  assign stat.neg  = acc_r[ACC_W-1];

endmodule

@@ rtl/quartic_sign_step_root_search.sv @@
// root search for a monic quartic with integer coefficients held in apb registers
// in_tdata carries two signed fixed-point endpoints; the search starts at their
// midpoint and moves by halving steps against the sign of the polynomial
// one word in gives one word out: the final estimate, the move count and a
// flag on out_tuser that is set when the polynomial was exactly zero
// every polynomial evaluation runs horner on one shared 33x40 multiplier that
// walks a wide accumulator of NCH 32-bit chunks, 32 bits per cycle, with
// NCH = ceil((4*max(FRACTION_BITS, sat width)+35)/32)
// a search runs one evaluation per move, plus one more when an exact zero ends it
// in_tready is high only while no search runs; one word is worked at a time
// a finished result sits in the output register until out_tready takes it,
// and the next input word is accepted meanwhile; a new result waits for it
// reset (synchronous, active low) loads the default coefficients and tolerance,
// drops out_tvalid and returns the search to idle
// registers must be written only while the block is idle
module quartic_sign_step_root_search
  import qssrs_pkg::*;
#(
  parameter int FRACTION_BITS = 24,
  parameter int INTEGER_BITS  = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // start_point[39:0], far_point[79:40]
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // root[39:0], steps_taken[45:40], zero pad
  output logic                  out_tuser,  // exact_zero
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  localparam int SAT_W = (INTEGER_BITS + FRACTION_BITS < POINT_W) ?
                         (INTEGER_BITS + FRACTION_BITS) : POINT_W;
  localparam logic signed [POINT_W:0] SAT_HI = (41'sd1 <<< (SAT_W - 1)) - 41'sd1;
  localparam logic signed [POINT_W:0] SAT_LO = -SAT_HI - 41'sd1;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_START  = 4'b0010,
    S_EVAL   = 4'b0100,
    S_FINISH = 4'b1000
  } s_state_t;

  s_state_t              state_r, state_nxt;
  coef_set_t             coefs_r;
  logic [TOL_W-1:0]      tol_r;

  logic signed [POINT_W-1:0] est_r, est_nxt;
  logic signed [POINT_W-1:0] step_r, step_nxt;
  logic [STEPS_W-1:0]    count_r, count_nxt;
  logic                  exact_r, exact_nxt;

  logic                  out_valid_r;
  logic [POINT_W-1:0]    root_r;
  logic [STEPS_W-1:0]    steps_out_r;
  logic                  exact_out_r;
  logic                  out_load;

  logic                  h_start;
  horner_stat_t          h_stat;

  logic signed [POINT_W-1:0] pa, pb;
  logic signed [POINT_W:0]   sum_w, sum_r, diff_w, diff_r, half_w, half_r, q_r;
  logic signed [POINT_W:0]   moved, step_rnd;
  logic [POINT_W-1:0]    mag;
  logic [TOL_W-1:0]      tol_eff;
  logic                  cfg_wr;
  reg_idx_t              cfg_idx;

  function automatic logic signed [POINT_W-1:0] clamp(input logic signed [POINT_W:0] v);
    if (v > SAT_HI) return SAT_HI[POINT_W-1:0];
    if (v < SAT_LO) return SAT_LO[POINT_W-1:0];
    return v[POINT_W-1:0];
  endfunction

  // configuration port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[CFG_ADDR_W-1:2]);

  always_comb begin
    case (cfg_idx)
      REG_CUBIC:  cfg_prdata = coefs_r.cubic;
      REG_SQUARE: cfg_prdata = coefs_r.square;
      REG_LINEAR: cfg_prdata = coefs_r.linear;
      REG_CONST:  cfg_prdata = coefs_r.const_term;
      REG_TOL:    cfg_prdata = {{(CFG_DATA_W-TOL_W){1'b0}}, tol_r};
      default:    cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coefs_r.cubic      <= 32'sd74;
      coefs_r.square     <= 32'sd531;
      coefs_r.linear     <= -32'sd106000;
      coefs_r.const_term <= -32'sd1216700;
      tol_r              <= 20'd2;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_CUBIC:  coefs_r.cubic      <= cfg_pwdata;
        REG_SQUARE: coefs_r.square     <= cfg_pwdata;
        REG_LINEAR: coefs_r.linear     <= cfg_pwdata;
        REG_CONST:  coefs_r.const_term <= cfg_pwdata;
        REG_TOL:    tol_r              <= cfg_pwdata[TOL_W-1:0];
        default:    ;
      endcase
    end
  end

  // start point and step, halves rounded toward zero
  assign pa     = in_tdata[POINT_W-1:0];
  assign pb     = in_tdata[2*POINT_W-1:POINT_W];
  assign sum_w  = {pa[POINT_W-1], pa} + {pb[POINT_W-1], pb};
  assign diff_w = {pb[POINT_W-1], pb} - {pa[POINT_W-1], pa};
  assign sum_r  = sum_w + $signed({{POINT_W{1'b0}}, sum_w[POINT_W]});
  assign diff_r = diff_w + $signed({{POINT_W{1'b0}}, diff_w[POINT_W]});
  assign half_w = diff_r >>> 1;
  assign half_r = {half_w[POINT_W-1], half_w[POINT_W-1:0]}
                + $signed({{POINT_W{1'b0}}, half_w[POINT_W-1]});
  assign q_r    = half_r >>> 1;

  // one move
  assign moved    = h_stat.neg ? ({est_r[POINT_W-1], est_r} + {step_r[POINT_W-1], step_r})
                               : ({est_r[POINT_W-1], est_r} - {step_r[POINT_W-1], step_r});
  assign step_rnd = ({step_r[POINT_W-1], step_r}
                  + $signed({{POINT_W{1'b0}}, step_r[POINT_W-1]})) >>> 1;
  assign mag      = step_r[POINT_W-1] ? (~step_r + 1'b1) : step_r;
  assign tol_eff  = (tol_r == '0) ? TOL_W'(1) : tol_r;

  assign in_tready = (state_r == S_IDLE);
  assign h_start   = (state_r == S_START);
  assign out_load  = (state_r == S_FINISH) && (!out_valid_r || out_tready);

  always_comb begin
    state_nxt = state_r;
    est_nxt   = est_r;
    step_nxt  = step_r;
    count_nxt = count_r;
    exact_nxt = exact_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          est_nxt   = clamp(sum_r >>> 1);
          step_nxt  = q_r[POINT_W-1:0];
          count_nxt = '0;
          exact_nxt = 1'b0;
          state_nxt = S_START;
        end
      end
      S_START: state_nxt = S_EVAL;
      S_EVAL: begin
        if (h_stat.done) begin
          if (h_stat.zero) begin
            exact_nxt = 1'b1;
            state_nxt = S_FINISH;
          end else begin
            est_nxt   = clamp(moved);
            count_nxt = count_r + 1'b1;
            if ((mag < {{(POINT_W-TOL_W){1'b0}}, tol_eff}) ||
                (count_r == MAX_MOVES - 1'b1)) begin
              state_nxt = S_FINISH;
            end else begin
              if (count_r != '0) step_nxt = step_rnd[POINT_W-1:0];
              state_nxt = S_START;
            end
          end
        end
      end
      S_FINISH: begin
        if (out_load) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      count_r     <= '0;
      exact_r     <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      exact_r <= exact_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    est_r  <= est_nxt;
    step_r <= step_nxt;
    if (out_load) begin
      root_r      <= est_r;
      steps_out_r <= count_r;
      exact_out_r <= exact_r;
    end
  end

  qssrs_horner #(
    .FRACTION_BITS (FRACTION_BITS),
    .SAT_W         (SAT_W)
  ) u_horner (
    .clk   (clk),
    .rst_n (rst_n),
    .start (h_start),
    .x     (est_r),
    .coefs (coefs_r),
    .stat  (h_stat)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W-POINT_W-STEPS_W){1'b0}}, steps_out_r, root_r};
  assign out_tuser  = exact_out_r;

endmodule
